@@ rtl/tssp_pkg.sv @@
// ----------------------------------------------------------------------------
// tssp_pkg
// shared types and constants of the tour segment swap perturbation block
// ----------------------------------------------------------------------------
package tssp_pkg;

  localparam int unsigned MaxCities = 256;
  localparam int unsigned TourDepth = MaxCities + 1;
  localparam int unsigned TourAw    = $clog2(TourDepth);
  localparam int unsigned DistWidth = 32;
  localparam int unsigned CostWidth = 48;
  localparam int unsigned DeltaWidth = 36;
  localparam int unsigned DrawWidth = 31;

  typedef enum logic [2:0] {
    CmdWrTour  = 3'd0,
    CmdWrDist  = 3'd1,
    CmdSetCost = 3'd2,
    CmdPerturb = 3'd3,
    CmdRdTour  = 3'd4
  } cmd_e;

  typedef enum logic [3:0] {
    StIdle,
    StMod,
    StSort,
    StFix,
    StTourRd,
    StDistRd,
    StCopyRd,
    StCopyWr,
    StDone,
    StRead
  } state_e;

endpackage

@@ rtl/tour_segment_swap_perturb.sv @@
// ----------------------------------------------------------------------------
// tour_segment_swap_perturb
// double-bridge style tour perturbation with a running tour cost
// ----------------------------------------------------------------------------
// channel   | ports                               | direction
// ----------+-------------------------------------+----------
// command   | start_i, busy_o, command_i ...      | in
// result    | done_o, read_city_o ... cut_fourth_o | out
// config    | cfg_we_i, cfg_wdata_i               | in
//
// loads and reads pass through a single busy state, StDone or StRead; the result
// strobe comes in the cycle after that state.
// a perturb reduces 4 draws with a 31-step restoring divider each, sorts and
// fixes up the cuts, makes 8 tour reads and 8 distance reads, copies the span
// entries (span = cut_fourth - cut_first + 1) into the scratch memory and writes
// them back into the tour, then finishes in StDone; the result strobe follows in
// the cycle after that state.
// reset clears the running cost and sets city_count to 256; no stall on output.
module tour_segment_swap_perturb (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  command_i,
  input  logic [8:0]  tour_index_i,
  input  logic [7:0]  city_id_i,
  input  logic [7:0]  from_city_i,
  input  logic [7:0]  to_city_i,
  input  logic [31:0] distance_value_i,
  input  logic [47:0] cost_value_i,
  input  logic [30:0] draw_a_i,
  input  logic [30:0] draw_b_i,
  input  logic [30:0] draw_c_i,
  input  logic [30:0] draw_d_i,
  output logic        done_o,
  output logic [7:0]  read_city_o,
  output logic signed [35:0] delta_cost_o,
  output logic [47:0] total_cost_o,
  output logic [8:0]  cut_first_o,
  output logic [8:0]  cut_second_o,
  output logic [8:0]  cut_third_o,
  output logic [8:0]  cut_fourth_o
);

  localparam int unsigned Aw = tssp_pkg::TourAw;

  tssp_pkg::state_e state_q, state_d;

  logic [8:0]  cnt_q, cnt_d;
  logic [47:0] cost_q, cost_d;
  logic [4:0]  step_q, step_d;
  logic [1:0]  dix_q, dix_d;
  logic [30:0] draw_q [4];
  logic [30:0] rem_q, rem_d;
  logic [30:0] quo_q, quo_d;
  logic [8:0]  p_q [4];
  logic [8:0]  p_d [4];
  logic [8:0]  n_q, n_d;
  logic [7:0]  tv_q [8];
  logic [3:0]  tix_q, tix_d;
  logic [49:0] pos_q, pos_d, neg_q, neg_d;
  logic [8:0]  w_q, w_d;
  logic [8:0]  len_q, len_d;
  logic        adj_q, adj_d;
  logic        done_q, done_d;
  logic [7:0]  rc_q, rc_d;
  logic signed [35:0] dl_q, dl_d;
  logic        rdok_q, rdok_d;

  // memories
  logic [7:0]  tour_mem [tssp_pkg::TourDepth];
  logic [7:0]  scr_mem  [tssp_pkg::TourDepth];
  logic [31:0] dist_mem [65536];

  logic        t_we, t_re, s_we, s_re, d_we, d_re;
  logic [Aw-1:0] t_wa, t_ra, s_wa, s_ra;
  logic [7:0]  t_wd, s_wd, t_rd, s_rd;
  logic [15:0] d_wa, d_ra;
  logic [31:0] d_wd, d_rd;

  always_ff @(posedge clk_i) begin
    if (t_we) begin
      tour_mem[t_wa] <= t_wd;
    end
    if (t_re) begin
      t_rd <= tour_mem[t_ra];
    end
    if (s_we) begin
      scr_mem[s_wa] <= s_wd;
    end
    if (s_re) begin
      s_rd <= scr_mem[s_ra];
    end
    if (d_we) begin
      dist_mem[d_wa] <= d_wd;
    end
    if (d_re) begin
      d_rd <= dist_mem[d_ra];
    end
  end

  logic [8:0] cnt_eff;
  always_comb begin
    cnt_eff = cnt_q;
    if (cnt_q < 9'd5) begin
      cnt_eff = 9'd5;
    end else if (cnt_q > 9'(tssp_pkg::MaxCities)) begin
      cnt_eff = 9'(tssp_pkg::MaxCities);
    end
  end

  // tour position of each lookup: p0,p1,p2,p3,p0-1,p1+1,p2-1,p3+1
  logic [8:0] tpos;
  always_comb begin
    case (tix_q[2:0])
      3'd0: tpos = p_q[0];
      3'd1: tpos = p_q[1];
      3'd2: tpos = p_q[2];
      3'd3: tpos = p_q[3];
      3'd4: tpos = p_q[0] - 9'd1;
      3'd5: tpos = p_q[1] + 9'd1;
      3'd6: tpos = p_q[2] - 9'd1;
      default: tpos = p_q[3] + 9'd1;
    endcase
  end

  // distance pairs (row,col) as tv indices; 0..3 positive, 4..7 negative
  logic [2:0] prow, pcol;
  always_comb begin
    prow = 3'd0;
    pcol = 3'd0;
    if (adj_q) begin
      case (tix_q[2:0])
        3'd0: begin prow = 3'd0; pcol = 3'd3; end
        3'd1: begin prow = 3'd1; pcol = 3'd7; end
        3'd2: begin prow = 3'd2; pcol = 3'd4; end
        3'd4: begin prow = 3'd0; pcol = 3'd4; end
        3'd5: begin prow = 3'd1; pcol = 3'd2; end
        3'd6: begin prow = 3'd3; pcol = 3'd7; end
        default: begin prow = 3'd0; pcol = 3'd0; end
      endcase
    end else begin
      case (tix_q[2:0])
        3'd0: begin prow = 3'd0; pcol = 3'd6; end
        3'd1: begin prow = 3'd1; pcol = 3'd7; end
        3'd2: begin prow = 3'd2; pcol = 3'd4; end
        3'd3: begin prow = 3'd3; pcol = 3'd5; end
        3'd4: begin prow = 3'd0; pcol = 3'd4; end
        3'd5: begin prow = 3'd1; pcol = 3'd5; end
        3'd6: begin prow = 3'd2; pcol = 3'd6; end
        default: begin prow = 3'd3; pcol = 3'd7; end
      endcase
    end
  end

  // restoring divider step
  logic [31:0] trial;
  assign trial = {rem_q, quo_q[30]} - {23'd0, n_q};

  // cnt_eff/10 by reciprocal multiply, exact for values below 1029
  logic [9:0] lim;
  assign lim = 10'((18'(cnt_eff) * 18'd205) >> 11);

  // scratch order source position for write index w
  logic [8:0] len2, mid;
  assign len2 = p_q[3] - p_q[2] + 9'd1;
  assign mid  = p_q[2] - p_q[1] - 9'd1;
  logic [8:0] srcpos;
  always_comb begin
    if (w_q < len2) begin
      srcpos = p_q[2] + w_q;
    end else if (w_q < len2 + mid) begin
      srcpos = p_q[1] + 9'd1 + (w_q - len2);
    end else begin
      srcpos = p_q[0] + (w_q - len2 - mid);
    end
  end

  logic [49:0] sum_c;
  always_comb begin
    state_d = state_q;
    cost_d  = cost_q;
    step_d  = step_q;
    dix_d   = dix_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    for (int i = 0; i < 4; i++) begin
      p_d[i] = p_q[i];
    end
    n_d    = n_q;
    tix_d  = tix_q;
    pos_d  = pos_q;
    neg_d  = neg_q;
    w_d    = w_q;
    len_d  = len_q;
    adj_d  = adj_q;
    done_d = 1'b0;
    rc_d   = 8'd0;
    dl_d   = dl_q;
    rdok_d = rdok_q;
    cnt_d  = cfg_we_i ? cfg_wdata_i : cnt_q;
    t_we = 1'b0; t_re = 1'b0; s_we = 1'b0; s_re = 1'b0; d_we = 1'b0; d_re = 1'b0;
    t_wa = '0; t_ra = '0; s_wa = '0; s_ra = '0; t_wd = '0; s_wd = '0;
    d_wa = '0; d_ra = '0; d_wd = '0;
    sum_c = '0;
    case (state_q)
      tssp_pkg::StIdle: begin
        if (start_i) begin
          dl_d = '0;
          for (int i = 0; i < 4; i++) begin
            p_d[i] = '0;
          end
          case (command_i)
            tssp_pkg::CmdWrTour: begin
              t_we = (tour_index_i <= 9'(tssp_pkg::MaxCities));
              t_wa = Aw'(tour_index_i);
              t_wd = city_id_i;
              state_d = tssp_pkg::StDone;
            end
            tssp_pkg::CmdWrDist: begin
              d_we = 1'b1;
              d_wa = {from_city_i, to_city_i};
              d_wd = distance_value_i;
              state_d = tssp_pkg::StDone;
            end
            tssp_pkg::CmdSetCost: begin
              cost_d = cost_value_i;
              state_d = tssp_pkg::StDone;
            end
            tssp_pkg::CmdPerturb: begin
              n_d = cnt_eff - 9'd4;
              dix_d = 2'd0;
              step_d = 5'd0;
              rem_d = '0;
              quo_d = draw_a_i;
              state_d = tssp_pkg::StMod;
            end
            tssp_pkg::CmdRdTour: begin
              t_re = 1'b1;
              t_ra = Aw'(tour_index_i);
              rdok_d = (tour_index_i <= 9'(tssp_pkg::MaxCities));
              state_d = tssp_pkg::StRead;
            end
            default: state_d = tssp_pkg::StDone;
          endcase
        end
      end
      tssp_pkg::StMod: begin
        if (trial[31]) begin
          rem_d = {rem_q[29:0], quo_q[30]};
        end else begin
          rem_d = trial[30:0];
        end
        quo_d = {quo_q[29:0], 1'b0};
        step_d = step_q + 5'd1;
        if (step_q == 5'd30) begin
          p_d[dix_q] = 9'(rem_d) + 9'd1;
          step_d = 5'd0;
          rem_d = '0;
          dix_d = dix_q + 2'd1;
          quo_d = draw_q[dix_q + 2'd1];
          if (dix_q == 2'd3) begin
            step_d = 5'd0;
            state_d = tssp_pkg::StSort;
          end
        end
      end
      tssp_pkg::StSort: begin
        // odd-even transposition, 4 passes alternating
        if (step_q[0] == 1'b0) begin
          if (p_q[0] > p_q[1]) begin p_d[0] = p_q[1]; p_d[1] = p_q[0]; end
          if (p_q[2] > p_q[3]) begin p_d[2] = p_q[3]; p_d[3] = p_q[2]; end
        end else begin
          if (p_q[1] > p_q[2]) begin p_d[1] = p_q[2]; p_d[2] = p_q[1]; end
        end
        step_d = step_q + 5'd1;
        if (step_q == 5'd3) begin
          step_d = 5'd0;
          state_d = tssp_pkg::StFix;
        end
      end
      tssp_pkg::StFix: begin
        // steps 0..2 force strict increase, 3 limits segments
        case (step_q[1:0])
          2'd0: if (p_q[1] <= p_q[0]) p_d[1] = p_q[0] + 9'd1;
          2'd1: if (p_q[2] <= p_q[1]) p_d[2] = p_q[1] + 9'd1;
          2'd2: if (p_q[3] <= p_q[2]) p_d[3] = p_q[2] + 9'd1;
          default: begin
            if (10'(p_q[1] - p_q[0]) > lim) p_d[1] = p_q[0] + 9'(lim);
            if (10'(p_q[3] - p_q[2]) > lim) p_d[3] = p_q[2] + 9'(lim);
          end
        endcase
        step_d = step_q + 5'd1;
        if (step_q == 5'd3) begin
          step_d = 5'd0;
          tix_d = 4'd0;
          state_d = tssp_pkg::StTourRd;
        end
      end
      tssp_pkg::StTourRd: begin
        // issue read tix, capture previous
        adj_d = (p_q[2] == p_q[1] + 9'd1);
        if (tix_q < 4'd8) begin
          t_re = 1'b1;
          t_ra = Aw'(tpos);
        end
        tix_d = tix_q + 4'd1;
        if (tix_q == 4'd8) begin
          tix_d = 4'd0;
          pos_d = '0;
          neg_d = '0;
          state_d = tssp_pkg::StDistRd;
        end
      end
      tssp_pkg::StDistRd: begin
        if (tix_q < 4'd8) begin
          d_re = 1'b1;
          d_ra = {tv_q[prow], tv_q[pcol]};
        end
        if (tix_q != 4'd0 && !(adj_q && tix_q == 4'd4) && !(adj_q && tix_q == 4'd8)) begin
          if (tix_q <= 4'd4) begin
            pos_d = pos_q + 50'(d_rd);
          end else begin
            neg_d = neg_q + 50'(d_rd);
          end
        end
        tix_d = tix_q + 4'd1;
        if (tix_q == 4'd8) begin
          w_d = '0;
          len_d = p_q[3] - p_q[0] + 9'd1;
          state_d = tssp_pkg::StCopyRd;
        end
      end
      tssp_pkg::StCopyRd: begin
        // read tour[srcpos] then write scratch in the next cycle
        t_re = 1'b1;
        t_ra = Aw'(srcpos);
        state_d = tssp_pkg::StCopyWr;
        if (w_q == len_q) begin
          t_re = 1'b0;
          w_d = '0;
          s_re = 1'b1;
          s_ra = '0;
          step_d = 5'd1;
          state_d = tssp_pkg::StCopyWr;
        end
      end
      tssp_pkg::StCopyWr: begin
        if (step_q == 5'd0) begin
          s_we = 1'b1;
          s_wa = Aw'(w_q);
          s_wd = t_rd;
          w_d = w_q + 9'd1;
          state_d = tssp_pkg::StCopyRd;
        end else begin
          // write back phase: s_rd holds scratch[w]
          t_we = 1'b1;
          t_wa = Aw'(p_q[0] + w_q);
          t_wd = s_rd;
          w_d = w_q + 9'd1;
          s_re = 1'b1;
          s_ra = Aw'(w_q + 9'd1);
          if (w_q + 9'd1 == len_q) begin
            dl_d = 36'(pos_q - neg_q);
            if (pos_q >= neg_q) begin
              sum_c = 50'(cost_q) + (pos_q - neg_q);
              cost_d = (sum_c > 50'(48'hFFFF_FFFF_FFFF)) ? 48'hFFFF_FFFF_FFFF : 48'(sum_c);
            end else begin
              cost_d = ((neg_q - pos_q) > 50'(cost_q)) ? 48'd0 : 48'(50'(cost_q) - (neg_q - pos_q));
            end
            state_d = tssp_pkg::StDone;
          end
        end
      end
      tssp_pkg::StRead: begin
        rc_d = rdok_q ? t_rd : 8'd0;
        done_d = 1'b1;
        state_d = tssp_pkg::StIdle;
      end
      tssp_pkg::StDone: begin
        done_d = 1'b1;
        state_d = tssp_pkg::StIdle;
      end
      default: state_d = tssp_pkg::StIdle;
    endcase
  end

  // capture tour values in the cycle after each read, and the draws at a start
  always_ff @(posedge clk_i) begin
    if (state_q == tssp_pkg::StTourRd && tix_q != 4'd0) begin
      tv_q[3'(tix_q - 4'd1)] <= t_rd;
    end
    if (state_q == tssp_pkg::StIdle && start_i) begin
      draw_q[0] <= draw_a_i;
      draw_q[1] <= draw_b_i;
      draw_q[2] <= draw_c_i;
      draw_q[3] <= draw_d_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tssp_pkg::StIdle;
      cnt_q   <= 9'd256;
      cost_q  <= '0;
      done_q  <= 1'b0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      cost_q  <= cost_d;
      done_q  <= done_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dix_q <= dix_d; rem_q <= rem_d; quo_q <= quo_d; n_q <= n_d;
    tix_q <= tix_d; pos_q <= pos_d; neg_q <= neg_d; w_q <= w_d;
    len_q <= len_d; adj_q <= adj_d; rc_q <= rc_d; dl_q <= dl_d;
    rdok_q <= rdok_d;
    for (int i = 0; i < 4; i++) begin
      p_q[i] <= p_d[i];
    end
  end

  assign busy_o       = (state_q != tssp_pkg::StIdle);
  assign done_o       = done_q;
  assign read_city_o  = rc_q;
  assign delta_cost_o = dl_q;
  assign total_cost_o = cost_q;
  assign cut_first_o  = p_q[0];
  assign cut_second_o = p_q[1];
  assign cut_third_o  = p_q[2];
  assign cut_fourth_o = p_q[3];

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for tour_segment_swap_perturb. A self-contained predictor tracks
// the tour, the distance table, the city count and the running cost. It checks
// every result strobe field by field, in order. The tables are loaded first.
// After a directed pass over the edge cases, random command mixes run under
// several city counts, including the extremes and values outside the range.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct {
    logic [2:0]  cmd;
    logic [8:0]  index;
    logic [7:0]  city;
    logic [7:0]  from_city;
    logic [7:0]  to_city;
    logic [31:0] distance;
    logic [47:0] cost;
    logic [30:0] draw [4];
  } tour_cmd_t;

  typedef struct {
    logic [7:0]  read_city;
    logic [35:0] delta;
    logic [47:0] total;
    logic [8:0]  cut [4];
  } tour_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [8:0] cfg_wdata_i = '0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [2:0] command_i = '0;
  logic [8:0] tour_index_i = '0;
  logic [7:0] city_id_i = '0, from_city_i = '0, to_city_i = '0;
  logic [31:0] distance_value_i = '0;
  logic [47:0] cost_value_i = '0;
  logic [30:0] draw_a_i = '0, draw_b_i = '0, draw_c_i = '0, draw_d_i = '0;
  logic done_o;
  logic [7:0] read_city_o;
  logic signed [35:0] delta_cost_o;
  logic [47:0] total_cost_o;
  logic [8:0] cut_first_o, cut_second_o, cut_third_o, cut_fourth_o;

  // predictor state
  logic [7:0]  tour_mem [tssp_pkg::TourDepth];
  logic [31:0] dist_mem [65536];
  logic [47:0] cost_acc;
  logic [8:0]  city_count_reg;

  tour_result_t expected_q[$];
  int  error_count = 0;
  int  idle_cycles = 0;
  bit  no_gap = 1'b0;

  localparam int unsigned WatchdogLimit = 20000;
  localparam logic [47:0] CostMax = 48'hFFFF_FFFF_FFFF;

  tour_segment_swap_perturb dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .start_i, .busy_o, .command_i,
    .tour_index_i, .city_id_i, .from_city_i, .to_city_i, .distance_value_i,
    .cost_value_i, .draw_a_i, .draw_b_i, .draw_c_i, .draw_d_i, .done_o,
    .read_city_o, .delta_cost_o, .total_cost_o, .cut_first_o, .cut_second_o,
    .cut_third_o, .cut_fourth_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // cities used in the tour: 0..7 and 248..255, so every city bit toggles
  function automatic logic [7:0] pool_city(int k);
    return (k < 8) ? 8'(k) : 8'(240 + k);
  endfunction

  function automatic logic [63:0] dist_of(logic [7:0] row, logic [7:0] col);
    return {32'd0, dist_mem[{row, col}]};
  endfunction

  function automatic tour_result_t compute_swap(tour_cmd_t c);
    tour_result_t r;
    logic [63:0] n, lim, pos, neg, v, diff;
    logic [63:0] p [4];
    logic [7:0] seg [$];
    int i;
    n = 64'(city_count_reg);
    if (n < 5) n = 5;
    if (n > tssp_pkg::MaxCities) n = tssp_pkg::MaxCities;
    for (i = 0; i < 4; i++) p[i] = {33'd0, c.draw[i]} % (n - 4) + 1;
    for (i = 0; i < 3; i++)
      for (int j = 0; j < 3 - i; j++)
        if (p[j] > p[j+1]) begin
          v = p[j]; p[j] = p[j+1]; p[j+1] = v;
        end
    for (i = 0; i < 3; i++) if (p[i+1] <= p[i]) p[i+1] = p[i] + 1;
    lim = n / 10;
    if (p[1] - p[0] > lim) p[1] = p[0] + lim;
    if (p[3] - p[2] > lim) p[3] = p[2] + lim;
    if (p[2] == p[1] + 1) begin
      // adjacent segments: the edges p0-1/p0, p1/p2 and p3/p3+1 change
      pos = dist_of(tour_mem[p[0]], tour_mem[p[3]])
          + dist_of(tour_mem[p[1]], tour_mem[p[3]+1])
          + dist_of(tour_mem[p[2]], tour_mem[p[0]-1]);
      neg = dist_of(tour_mem[p[0]], tour_mem[p[0]-1])
          + dist_of(tour_mem[p[1]], tour_mem[p[2]])
          + dist_of(tour_mem[p[3]], tour_mem[p[3]+1]);
    end else begin
      pos = dist_of(tour_mem[p[0]], tour_mem[p[2]-1])
          + dist_of(tour_mem[p[1]], tour_mem[p[3]+1])
          + dist_of(tour_mem[p[2]], tour_mem[p[0]-1])
          + dist_of(tour_mem[p[3]], tour_mem[p[1]+1]);
      neg = dist_of(tour_mem[p[0]], tour_mem[p[0]-1])
          + dist_of(tour_mem[p[1]], tour_mem[p[1]+1])
          + dist_of(tour_mem[p[2]], tour_mem[p[2]-1])
          + dist_of(tour_mem[p[3]], tour_mem[p[3]+1]);
    end
    for (v = p[2]; v <= p[3]; v++) seg.push_back(tour_mem[v]);
    for (v = p[1] + 1; v < p[2]; v++) seg.push_back(tour_mem[v]);
    for (v = p[0]; v <= p[1]; v++) seg.push_back(tour_mem[v]);
    foreach (seg[k]) tour_mem[p[0] + k] = seg[k];
    if (pos >= neg) begin
      diff = pos - neg;
      cost_acc = (diff > {16'd0, CostMax - cost_acc}) ? CostMax : cost_acc + diff[47:0];
    end else begin
      diff = neg - pos;
      cost_acc = (diff > {16'd0, cost_acc}) ? 48'd0 : cost_acc - diff[47:0];
    end
    r.read_city = '0;
    r.delta = 36'(pos - neg);
    for (i = 0; i < 4; i++) r.cut[i] = p[i][8:0];
    return r;
  endfunction

  function automatic tour_result_t predict_item(tour_cmd_t c);
    tour_result_t r;
    r.read_city = '0;
    r.delta = '0;
    for (int i = 0; i < 4; i++) r.cut[i] = '0;
    case (c.cmd)
      tssp_pkg::CmdWrTour:  if (c.index < tssp_pkg::TourDepth) tour_mem[c.index] = c.city;
      tssp_pkg::CmdWrDist:  dist_mem[{c.from_city, c.to_city}] = c.distance;
      tssp_pkg::CmdSetCost: cost_acc = c.cost;
      tssp_pkg::CmdPerturb: r = compute_swap(c);
      tssp_pkg::CmdRdTour:  if (c.index < tssp_pkg::TourDepth) r.read_city = tour_mem[c.index];
      default: ;
    endcase
    r.total = cost_acc;
    return r;
  endfunction

  task automatic send_item(tour_cmd_t c);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 9);
    @(negedge clk_i);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    command_i <= c.cmd;
    tour_index_i <= c.index;
    city_id_i <= c.city;
    from_city_i <= c.from_city;
    to_city_i <= c.to_city;
    distance_value_i <= c.distance;
    cost_value_i <= c.cost;
    draw_a_i <= c.draw[0];
    draw_b_i <= c.draw[1];
    draw_c_i <= c.draw[2];
    draw_d_i <= c.draw[3];
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    expected_q.push_back(predict_item(c));
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_city_count(logic [8:0] value);
    wait_drained();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    city_count_reg = value;
  endtask

  function automatic tour_cmd_t blank_cmd(logic [2:0] cmd);
    tour_cmd_t c;
    c.cmd = cmd;
    c.index = '0;
    c.city = '0;
    c.from_city = '0;
    c.to_city = '0;
    c.distance = '0;
    c.cost = '0;
    for (int i = 0; i < 4; i++) c.draw[i] = '0;
    return c;
  endfunction

  function automatic tour_cmd_t perturb_cmd();
    tour_cmd_t c;
    c = blank_cmd(tssp_pkg::CmdPerturb);
    for (int i = 0; i < 4; i++) c.draw[i] = 31'($urandom);
    // equal draws exercise the strictly-increasing fixup
    if ($urandom_range(0, 7) == 0) c.draw[1] = c.draw[0];
    if ($urandom_range(0, 7) == 0) c.draw[3] = c.draw[2];
    return c;
  endfunction

  function automatic tour_cmd_t random_cmd();
    tour_cmd_t c;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      c = perturb_cmd();
    end else if (pick < 65) begin
      c = blank_cmd(tssp_pkg::CmdWrTour);
      c.index = ($urandom_range(0, 9) == 0) ? 9'($urandom) : 9'($urandom_range(0, 256));
      c.city = pool_city($urandom_range(0, 15));
    end else if (pick < 75) begin
      c = blank_cmd(tssp_pkg::CmdWrDist);
      if ($urandom_range(0, 1)) begin
        c.from_city = pool_city($urandom_range(0, 15));
        c.to_city = pool_city($urandom_range(0, 15));
      end else begin
        c.from_city = 8'($urandom);
        c.to_city = 8'($urandom);
      end
      c.distance = $urandom;
    end else if (pick < 88) begin
      c = blank_cmd(tssp_pkg::CmdRdTour);
      c.index = ($urandom_range(0, 9) == 0) ? 9'($urandom) : 9'($urandom_range(0, 256));
    end else if (pick < 95) begin
      c = blank_cmd(tssp_pkg::CmdSetCost);
      c.cost = {16'($urandom), 32'($urandom)};
    end else begin
      c = blank_cmd(3'($urandom_range(5, 7)));
    end
    return c;
  endfunction

  // whole tour and the full distance matrix of the city pool
  task automatic test_load_tables();
    tour_cmd_t c;
    for (int i = 0; i < tssp_pkg::TourDepth; i++) begin
      c = blank_cmd(tssp_pkg::CmdWrTour);
      c.index = 9'(i);
      c.city = pool_city($urandom_range(0, 15));
      send_item(c);
    end
    for (int a = 0; a < 16; a++)
      for (int b = 0; b < 16; b++) begin
        c = blank_cmd(tssp_pkg::CmdWrDist);
        c.from_city = pool_city(a);
        c.to_city = pool_city(b);
        c.distance = $urandom;
        send_item(c);
      end
  endtask

  task automatic test_edges();
    tour_cmd_t c;
    c = blank_cmd(tssp_pkg::CmdWrTour); c.index = 9'd256; c.city = 8'd255; send_item(c);
    c = blank_cmd(tssp_pkg::CmdRdTour); c.index = 9'd256; send_item(c);
    c = blank_cmd(tssp_pkg::CmdWrTour); c.index = 9'd0; c.city = 8'd0; send_item(c);
    c = blank_cmd(tssp_pkg::CmdRdTour); c.index = 9'd0; send_item(c);
    // out-of-range writes are dropped, reads give zero
    c = blank_cmd(tssp_pkg::CmdWrTour); c.index = 9'd511; c.city = 8'd7; send_item(c);
    c = blank_cmd(tssp_pkg::CmdWrTour); c.index = 9'd257; c.city = 8'd248; send_item(c);
    c = blank_cmd(tssp_pkg::CmdRdTour); c.index = 9'd257; send_item(c);
    c = blank_cmd(tssp_pkg::CmdRdTour); c.index = 9'd511; send_item(c);
    c = blank_cmd(tssp_pkg::CmdWrDist); c.from_city = 8'd255; c.to_city = 8'd0;
    c.distance = 32'hFFFF_FFFF; send_item(c);
    c = blank_cmd(tssp_pkg::CmdWrDist); c.from_city = 8'd0; c.to_city = 8'd255;
    c.distance = 32'd0; send_item(c);
    for (int k = 5; k < 8; k++) send_item(blank_cmd(3'(k)));
    c = perturb_cmd();
    for (int i = 0; i < 4; i++) c.draw[i] = '0;
    send_item(c);
    for (int i = 0; i < 4; i++) c.draw[i] = '1;
    send_item(c);
    c.draw[0] = '0; c.draw[1] = '1; c.draw[2] = 31'd1; c.draw[3] = 31'd2;
    send_item(c);
  endtask

  task automatic test_cost_saturation();
    tour_cmd_t c;
    for (int r = 0; r < 4; r++) begin
      c = blank_cmd(tssp_pkg::CmdSetCost); c.cost = CostMax; send_item(c);
      send_item(perturb_cmd());
      c = blank_cmd(tssp_pkg::CmdSetCost); c.cost = '0; send_item(c);
      send_item(perturb_cmd());
    end
  endtask

  task automatic test_random_mix(int count);
    no_gap = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        // let the block drain completely before going on
        wait_drained();
        no_gap = !no_gap;
      end
      send_item(random_cmd());
    end
    no_gap = 1'b0;
  endtask

  always @(posedge clk_i) begin
    tour_result_t e;
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, total_cost %h", $time, total_cost_o);
        error_count++;
      end else begin
        e = expected_q.pop_front();
        if (read_city_o !== e.read_city) begin
          $display("%0t: read_city exp %h got %h", $time, e.read_city, read_city_o);
          error_count++;
        end
        if (delta_cost_o !== e.delta) begin
          $display("%0t: delta_cost exp %h got %h", $time, e.delta, delta_cost_o);
          error_count++;
        end
        if (total_cost_o !== e.total) begin
          $display("%0t: total_cost exp %h got %h", $time, e.total, total_cost_o);
          error_count++;
        end
        if ({cut_first_o, cut_second_o, cut_third_o, cut_fourth_o}
            !== {e.cut[0], e.cut[1], e.cut[2], e.cut[3]}) begin
          $display("%0t: cuts exp %0d %0d %0d %0d got %0d %0d %0d %0d", $time,
                   e.cut[0], e.cut[1], e.cut[2], e.cut[3],
                   cut_first_o, cut_second_o, cut_third_o, cut_fourth_o);
          error_count++;
        end
      end
    end
  end

  // counts cycles with no transfer on either side and stops the run at WatchdogLimit
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    logic [8:0] counts [8];
    counts = '{9'd256, 9'd5, 9'd0, 9'd4, 9'd511, 9'd257, 9'd10, 9'd37};
    cost_acc = '0;
    city_count_reg = 9'd256;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_load_tables();
    test_edges();
    test_cost_saturation();
    foreach (counts[k]) begin
      write_city_count(counts[k]);
      test_random_mix(67);
    end
    write_city_count(9'($urandom_range(5, 256)));
    test_random_mix(67);
    wait_drained();
    repeat (20) @(negedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
